// ===== src/assert_macros.svh =====
// Assertion helper macros, used by double_sha256_hasher.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check a property on every clock edge while out of reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ===== src/dsha_pkg.sv =====
// ----------------------------------------------------------------------------
// dsha_pkg: shared SHA-256 constants and types
// Round constants, initial hash values and the round-unit control struct.
// ----------------------------------------------------------------------------
package dsha_pkg;

    localparam int unsigned RoundCount = 64;

    typedef logic [31:0] t_word;
    typedef t_word t_state [8];

    // Controls for the round unit.
    typedef struct packed {
        logic       load;      // load working vars from chaining value
        logic       step;      // run one round
        logic [5:0] round;     // round number
    } t_round_ctl;

    localparam t_word RoundK [RoundCount] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam t_word InitHash [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PadByte = 8'h80;

    function automatic t_word rotr(input t_word x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

// ===== src/dsha_round.sv =====
// ----------------------------------------------------------------------------
// dsha_round: SHA-256 round unit
// Holds the eight working variables and a 16-word message schedule window,
// and runs one compression round per step.
// ----------------------------------------------------------------------------
module dsha_round (
    input  logic                i_clk,
    input  dsha_pkg::t_round_ctl i_ctl,
    input  dsha_pkg::t_word     i_cv [8],
    input  dsha_pkg::t_word     i_blk [16],
    output dsha_pkg::t_word     o_var [8]
);
    import dsha_pkg::*;

    t_word r_v [8];
    t_word r_w [16];
    t_word w_cur, w_new, s0, s1, t1, t2, e, a;

    always_comb begin
        s0    = rotr(r_w[1], 7) ^ rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        s1    = rotr(r_w[14], 17) ^ rotr(r_w[14], 19) ^ (r_w[14] >> 10);
        w_new = r_w[0] + s0 + r_w[9] + s1;
        w_cur = r_w[0];
        e     = r_v[4];
        a     = r_v[0];
        t1    = r_v[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
              + ((e & r_v[5]) ^ (~e & r_v[6])) + RoundK[i_ctl.round] + w_cur;
        t2    = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
              + ((a & r_v[1]) ^ (a & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_v <= i_cv;
            r_w <= i_blk;
        end else if (i_ctl.step) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
            // advance the schedule window
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
            r_w[15] <= w_new;
        end
    end

    assign o_var = r_v;

endmodule

// ===== src/double_sha256_hasher.sv =====
// Flow: a byte that fills no block is simply stored; a byte that fills a block
// starts load, 64 rounds on one shared round unit, then add-back.
// The final byte adds one padded block (or two on a padding spill), a second
// pass when double hashing, then the digest words, one per accepted transfer.
// The input is stalled while a block is compressed or the digest is sent.
// Reset (synchronous, i_rst_n low): chaining value to initial hash, counters clear.
// ----------------------------------------------------------------------------
// double_sha256_hasher: streaming SHA-256 / double SHA-256
// Buffers bytes into 64-byte blocks, pads, compresses with one round unit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module double_sha256_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // end_of_message
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] word_index
    output logic        m_axis_tlast    // last_word
);
    import dsha_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_LOAD, S_ROUND, S_ADD, S_PAD, S_OUT
    } t_state_e;

    // Phase of a final sequence.
    typedef enum logic [1:0] {
        P_DATA, P_SPILL, P_LEN, P_SECOND
    } t_phase_e;

    t_state_e    r_state;
    t_phase_e    r_phase;
    logic        r_dbl;
    logic        r_final;
    logic [5:0]  r_fill;
    logic [60:0] r_count;
    logic [5:0]  r_round;
    logic [2:0]  r_idx;
    t_word       r_blk [16];    // block buffer, byte 0 in the top bits of word 0
    t_word       r_cv [8];
    t_word       rv [8];
    t_word       pad_blk [16];
    t_word       dig_blk [16];
    logic        keep_data;
    logic        spill_now;
    t_round_ctl  ctl;

    assign ctl.load  = (r_state == S_LOAD);
    assign ctl.step  = (r_state == S_ROUND);
    assign ctl.round = r_round;

    dsha_round u_round (
        .i_clk (i_clk),
        .i_ctl (ctl),
        .i_cv  (r_cv),
        .i_blk (r_blk),
        .o_var (rv)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = {5'd0, r_idx, r_cv[r_idx]};
    assign m_axis_tlast  = (r_idx == 3'd7);

    logic [63:0] bitlen;
    assign bitlen = {r_count, 3'b000};

    // The second pass of a spill holds no message bytes, only zeros and length.
    assign keep_data = (r_phase != P_SPILL);
    // No room for the length after the pad byte: close this block with zeros.
    assign spill_now = keep_data && (r_fill > 6'd55);

    // Padded block: message bytes, pad byte, zero fill, big-endian bit length.
    always_comb begin
        for (int i = 0; i < 16; i++) begin
            if (!spill_now && i >= 14) begin
                pad_blk[i] = (i == 14) ? bitlen[63:32] : bitlen[31:0];
            end else begin
                for (int j = 0; j < 4; j++) begin
                    if (keep_data && (4*i + j) < int'(r_fill))
                        pad_blk[i][8*(3-j) +: 8] = r_blk[i][8*(3-j) +: 8];
                    else if (keep_data && (4*i + j) == int'(r_fill))
                        pad_blk[i][8*(3-j) +: 8] = PadByte;
                    else
                        pad_blk[i][8*(3-j) +: 8] = 8'h00;
                end
            end
        end
    end

    // Second-pass block: first digest, pad byte, length of 256 bits.
    always_comb begin
        for (int i = 0; i < 16; i++) begin
            if (i < 8)
                dig_blk[i] = r_cv[i] + rv[i];
            else if (i == 8)
                dig_blk[i] = {PadByte, 24'd0};
            else if (i == 15)
                dig_blk[i] = 32'd256;
            else
                dig_blk[i] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= P_DATA;
            r_dbl   <= 1'b1;
            r_final <= 1'b0;
            r_fill  <= '0;
            r_count <= '0;
            r_round <= '0;
            r_idx   <= '0;
            r_cv    <= InitHash;
        end else begin
            if (i_cfg_we) r_dbl <= i_cfg_wdata;
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_blk[r_fill[5:2]][{~r_fill[1:0], 3'b000} +: 8] <= s_axis_tdata;
                        r_fill  <= r_fill + 6'd1;
                        r_count <= r_count + 61'd1;
                        r_final <= s_axis_tlast;
                        r_phase <= P_DATA;
                        if (r_fill == 6'd63) r_state <= S_LOAD;
                        else if (s_axis_tlast) r_state <= S_PAD;
                    end
                end
                S_PAD: begin
                    r_blk   <= pad_blk;
                    r_phase <= spill_now ? P_SPILL : P_LEN;
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    r_round <= '0;
                    r_state <= S_ROUND;
                end
                S_ROUND: begin
                    r_round <= r_round + 6'd1;
                    if (r_round == 6'd63) r_state <= S_ADD;
                end
                S_ADD: begin
                    r_fill <= '0;
                    if (r_final && r_phase == P_LEN && r_dbl) begin
                        // rehash the 32-byte digest as a new message
                        r_blk   <= dig_blk;
                        r_cv    <= InitHash;
                        r_phase <= P_SECOND;
                        r_state <= S_LOAD;
                    end else begin
                        for (int i = 0; i < 8; i++) r_cv[i] <= r_cv[i] + rv[i];
                        if (!r_final) begin
                            r_state <= S_IDLE;
                        end else if (r_phase == P_DATA) begin
                            // last byte closed a block: pad in a fresh one
                            r_phase <= P_LEN;
                            r_state <= S_PAD;
                        end else if (r_phase == P_SPILL) begin
                            r_state <= S_PAD;
                        end else begin
                            r_idx   <= '0;
                            r_state <= S_OUT;
                        end
                    end
                end
                S_OUT: begin
                    if (m_axis_tready) begin
                        r_idx <= r_idx + 3'd1;
                        if (r_idx == 3'd7) begin
                            r_cv    <= InitHash;
                            r_count <= '0;
                            r_fill  <= '0;
                            r_final <= 1'b0;
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // The fill count stays clear while a data block is compressed.
    `ASSERT_CLK(a_fill_round, i_clk, i_rst_n,
        (r_state == S_ROUND && !r_final) |-> (r_fill == 6'd0),
        "fill check")
    // Input and output sides never open together.
    `ASSERT_CLK(a_excl, i_clk, i_rst_n, !(s_axis_tready && m_axis_tvalid), "both sides open")
    // Output words leave in order.
    `ASSERT_CLK(a_idx, i_clk, i_rst_n,
        (m_axis_tvalid && m_axis_tready && r_idx != 3'd7) |=> (r_idx == $past(r_idx) + 3'd1),
        "word index skipped")

endmodule
